### rtl/mbwd_pkg.sv
// Package for the marked-base window density block.
// Holds the shared widths, the threshold reset value and the word types passed between stages.
// No dependencies.
`default_nettype none

package mbwd_pkg;

  localparam int POS_W      = 31;
  localparam int CNT_W      = 16;
  localparam int OUT_CNT_W  = 10;
  localparam int THR_W      = 17;
  localparam int PROD_W     = 33;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  localparam logic [THR_W-1:0] THR_RESET = 17'd26214;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [THR_W-1:0] thr_t;

  // Window candidate from the tracker: still to be judged against the threshold
  typedef struct packed {
    logic valid;
    pos_t win_start;
    pos_t win_end;
    cnt_t count;
    cnt_t den;
  } cand_t;

  // Reported window payload
  typedef struct packed {
    pos_t                 win_start;
    pos_t                 win_end;
    logic [OUT_CNT_W-1:0] count;
  } win_t;

  typedef struct packed {
    logic valid;
    win_t win;
  } res_t;

endpackage

`default_nettype wire

### rtl/mbwd_if.sv
// Valid/ready channel interfaces for the window density block.
// Depends on mbwd_pkg for field widths.
`default_nettype none

interface mbwd_in_if;
  logic valid;
  logic ready;
  logic base_marked;
  logic last_base;

  modport source (output valid, output base_marked, output last_base, input ready);
  modport sink   (input valid, input base_marked, input last_base, output ready);
endinterface

interface mbwd_out_if;
  logic                           valid;
  logic                           ready;
  logic [mbwd_pkg::POS_W-1:0]     window_start;
  logic [mbwd_pkg::POS_W-1:0]     window_end;
  logic [mbwd_pkg::OUT_CNT_W-1:0] marked_count;

  modport source (output valid, output window_start, output window_end,
                  output marked_count, input ready);
  modport sink   (input valid, input window_start, input window_end,
                  input marked_count, output ready);
endinterface

`default_nettype wire

### rtl/mbwd_tracker.sv
// Window tracker: base position, round-robin window slots and their counters.
// Registers a window candidate when an accepted base completes the head window or ends a sequence. Uses mbwd_pkg.
`default_nettype none

module mbwd_tracker #(
  parameter int unsigned WINDOW_LENGTH  = 1000,
  parameter int unsigned WINDOW_OVERLAP = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            base_marked,
  input  logic            last_base,
  output mbwd_pkg::cand_t cand
);
  import mbwd_pkg::*;

  localparam int unsigned STEP_RAW = WINDOW_LENGTH / WINDOW_OVERLAP;
  localparam int unsigned STEP     = (STEP_RAW > 0) ? STEP_RAW : 1;
  localparam int unsigned SLOTS    = (WINDOW_LENGTH + STEP - 1) / STEP;
  localparam int unsigned SW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned PW       = (STEP > 1) ? $clog2(STEP) : 1;
  localparam int unsigned CW       = $clog2(WINDOW_LENGTH + 1);

  // control state
  pos_t              pos;
  logic [PW-1:0]     phase;
  logic [SW-1:0]     next_slot;
  logic [SW-1:0]     head;      // oldest open slot
  logic [SLOTS-1:0]  valid;
  logic [SLOTS-1:0]  valid_next;
  logic              cand_valid;

  // slot payload
  logic [CW-1:0]     cnt   [SLOTS];
  logic [CW-1:0]     seen  [SLOTS];
  pos_t              start [SLOTS];

  // updated slot values for this base
  logic [SLOTS-1:0]  slot_open;
  logic [SLOTS-1:0]  valid_u;
  logic [CW-1:0]     cnt_u   [SLOTS];
  logic [CW-1:0]     seen_u  [SLOTS];
  pos_t              start_u [SLOTS];

  logic              opening;
  logic              head_valid;
  logic [CW-1:0]     head_cnt;
  logic [CW-1:0]     head_seen;
  pos_t              head_start;
  pos_t              endpos;
  logic              complete;

  cnt_t              cand_count;
  cnt_t              cand_den;
  pos_t              cand_start;
  pos_t              cand_end;

  // per-slot update: open a slot on a step boundary, count into every open slot
  always_comb begin
    opening = (phase == '0);
    for (int k = 0; k < SLOTS; k++) begin
      slot_open[k] = opening && (next_slot == SW'(k));
      valid_u[k]   = valid[k] | slot_open[k];
      cnt_u[k]     = (slot_open[k] ? '0 : cnt[k]) + CW'(valid_u[k] & base_marked);
      seen_u[k]    = (slot_open[k] ? '0 : seen[k]) + CW'(valid_u[k]);
      start_u[k]   = slot_open[k] ? pos : start[k];
    end
  end

  // head slot is the only one that can complete, and the one cut at sequence end
  always_comb begin
    head_valid = valid_u[head];
    head_cnt   = cnt_u[head];
    head_seen  = seen_u[head];
    head_start = start_u[head];
    endpos     = pos + POS_W'(1);
    complete   = head_valid && !last_base && (head_seen == CW'(WINDOW_LENGTH));
    valid_next = valid_u;
    if (complete) begin
      valid_next[head] = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      phase      <= '0;
      next_slot  <= '0;
      head       <= '0;
      valid      <= '0;
      cand_valid <= 1'b0;
    end else begin
      cand_valid <= accept && (last_base ? head_valid : complete);
      if (accept) begin
        if (last_base) begin
          pos       <= '0;
          phase     <= '0;
          next_slot <= '0;
          head      <= '0;
          valid     <= '0;
        end else begin
          pos   <= endpos;
          phase <= (phase == PW'(STEP - 1)) ? '0 : phase + PW'(1);
          if (opening) begin
            next_slot <= (next_slot == SW'(SLOTS - 1)) ? '0 : next_slot + SW'(1);
          end
          if (complete) begin
            head <= (head == SW'(SLOTS - 1)) ? '0 : head + SW'(1);
          end
          valid <= valid_next;
        end
      end
    end
  end

  // slot and candidate payload
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < SLOTS; k++) begin
        cnt[k]   <= cnt_u[k];
        seen[k]  <= seen_u[k];
        start[k] <= start_u[k];
      end
      cand_start <= head_start;
      cand_end   <= endpos;
      cand_count <= CNT_W'(head_cnt);
      cand_den   <= last_base ? CNT_W'(head_seen) : CNT_W'(WINDOW_LENGTH);
    end
  end

  always_comb begin
    cand.valid     = cand_valid;
    cand.win_start = cand_start;
    cand.win_end   = cand_end;
    cand.count     = cand_count;
    cand.den       = cand_den;
  end

endmodule

`default_nettype wire

### rtl/mbwd_judge.sv
// Density judge: exact cross-multiplied compare of a window against the threshold.
// Registers the windows that pass. Uses mbwd_pkg.
`default_nettype none

module mbwd_judge (
  input  logic            clk,
  input  logic            rst,
  input  mbwd_pkg::thr_t  thr,
  input  mbwd_pkg::cand_t cand,
  output mbwd_pkg::res_t  res
);
  import mbwd_pkg::*;

  logic [PROD_W-1:0] lhs;
  logic [PROD_W-1:0] rhs;
  logic              pass;
  logic              res_valid;
  win_t              res_win;

  // count * 2^16 >= thr * den
  always_comb begin
    lhs  = {1'b0, cand.count, 16'h0000};
    rhs  = PROD_W'(thr) * PROD_W'(cand.den);
    pass = (lhs >= rhs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= cand.valid && pass;
    end
  end

  always_ff @(posedge clk) begin
    res_win.win_start <= cand.win_start;
    res_win.win_end   <= cand.win_end;
    res_win.count     <= cand.count[OUT_CNT_W-1:0];
  end

  always_comb begin
    res.valid = res_valid;
    res.win   = res_win;
  end

endmodule

`default_nettype wire

### rtl/mbwd_fifo.sv
// Small output queue that decouples the result side from the pipeline.
// Reports its fill level for input credit. Uses mbwd_pkg.
`default_nettype none

module mbwd_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  mbwd_pkg::res_t                res,
  input  logic                          rd_ready,
  output logic                          rd_valid,
  output mbwd_pkg::win_t                rd_win,
  output logic [mbwd_pkg::FIFO_CW-1:0]  fill
);
  import mbwd_pkg::*;

  win_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic               pop;

  assign rd_valid = (fill != '0);
  assign rd_win   = mem[rd_ptr];
  assign pop      = rd_valid && rd_ready;

  // pointers and fill level; space is guaranteed by the input credit
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (res.valid) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fill <= fill + FIFO_CW'(res.valid) - FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      mem[wr_ptr] <= res.win;
    end
  end

endmodule

`default_nettype wire

### rtl/marked_base_window_density_top.sv
// Path of a window word: tracker candidate register, judge result register, output queue head.
// Throughput: one base per cycle while in ready is high; the tracker updates all window slots in one pass.
// in ready drops only when the 4-word output queue plus words in flight is full.
// Reset (rst, synchronous): position, slots and queue clear; threshold returns to 26214.
// Top level of the marked-base window density block.
// Depends on mbwd_pkg, mbwd_if, mbwd_tracker, mbwd_judge and mbwd_fifo.
`default_nettype none

module marked_base_window_density_top #(
  parameter int unsigned WINDOW_LENGTH  = 1000,
  parameter int unsigned WINDOW_OVERLAP = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  mbwd_in_if.sink                    in_ch,
  mbwd_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [mbwd_pkg::THR_W-1:0] cfg_wdata
);
  import mbwd_pkg::*;

  thr_t               thr;
  cand_t              cand;
  res_t               res;
  win_t               head_win;
  logic [FIFO_CW-1:0] fill;
  logic [FIFO_CW-1:0] committed;
  logic               accept;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  // credit: queue words plus words still in the pipeline
  assign committed   = fill + FIFO_CW'(cand.valid) + FIFO_CW'(res.valid);
  assign in_ch.ready = (committed < FIFO_CW'(FIFO_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;

  mbwd_tracker #(
    .WINDOW_LENGTH  (WINDOW_LENGTH),
    .WINDOW_OVERLAP (WINDOW_OVERLAP)
  ) u_tracker (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .base_marked (in_ch.base_marked),
    .last_base   (in_ch.last_base),
    .cand        (cand)
  );

  mbwd_judge u_judge (
    .clk  (clk),
    .rst  (rst),
    .thr  (thr),
    .cand (cand),
    .res  (res)
  );

  mbwd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .rd_ready (out_ch.ready),
    .rd_valid (out_ch.valid),
    .rd_win   (head_win),
    .fill     (fill)
  );

  assign out_ch.window_start = head_win.win_start;
  assign out_ch.window_end   = head_win.win_end;
  assign out_ch.marked_count = head_win.count;

endmodule

`default_nettype wire

### rtl/mbwd_checker.sv
// Port-level checks for the window density block, bound to the top level.
// Depends on mbwd_pkg and marked_base_window_density_top.
`default_nettype none

module mbwd_checker #(
  parameter int unsigned WINDOW_LENGTH = 1000
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mbwd_pkg::POS_W-1:0]     window_start,
  input logic [mbwd_pkg::POS_W-1:0]     window_end,
  input logic [mbwd_pkg::OUT_CNT_W-1:0] marked_count
);
  import mbwd_pkg::*;

  pos_t span;
  assign span = window_end - window_start;

  // queue is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present right after reset");

  // with nothing queued there is always room for a new base
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output queue");

  // a stalled word stays until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(window_start) &&
    $stable(window_end) && $stable(marked_count))
    else $error("output word changed while stalled");

  // a reported window is never empty and never longer than a full window
  a_span: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (span != '0) && (span <= POS_W'(WINDOW_LENGTH)))
    else $error("reported window length out of range");

endmodule

bind marked_base_window_density_top mbwd_checker #(
  .WINDOW_LENGTH (WINDOW_LENGTH)
) u_mbwd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .window_start (out_ch.window_start),
  .window_end   (out_ch.window_end),
  .marked_count (out_ch.marked_count)
);

`default_nettype wire
